>>> hdl/mi3_pkg.sv
package mi3_pkg;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_SINGULAR = 2'd1,
		STATUS_SAT      = 2'd2
	} status_t;

	// cofactor i = m[COF_P[i]] * m[COF_Q[i]] - m[COF_R[i]] * m[COF_S[i]]
	localparam int unsigned COF_P [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int unsigned COF_Q [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int unsigned COF_R [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int unsigned COF_S [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

>>> hdl/mi3_cofactor.sv
module mi3_cofactor #(
	parameter int W = 32
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [W-1:0]   m      [9],
	output logic signed [2*W:0]   cof_s2 [9],
	output logic signed [W-1:0]   row_s2 [3]
);
	logic signed [2*W-1:0] pa_s1 [9];
	logic signed [2*W-1:0] pb_s1 [9];
	logic signed [W-1:0]   row_s1 [3];

	for (genvar i = 0; i < 9; i++) begin : g_cof
		always_ff @(posedge clk) begin
			if (en) begin
				pa_s1[i]  <= m[mi3_pkg::COF_P[i]] * m[mi3_pkg::COF_Q[i]];
				pb_s1[i]  <= m[mi3_pkg::COF_R[i]] * m[mi3_pkg::COF_S[i]];
				cof_s2[i] <= (2*W+1)'(pa_s1[i]) - (2*W+1)'(pb_s1[i]);
			end
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_row
		always_ff @(posedge clk) begin
			if (en) begin
				row_s1[k] <= m[k];
				row_s2[k] <= row_s1[k];
			end
		end
	end
endmodule

>>> hdl/mi3_det.sv
module mi3_det #(
	parameter int W = 32
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [2*W:0]     cof    [9],
	input  logic signed [W-1:0]     row    [3],
	output logic signed [2*W:0]     cof_s4 [9],
	output logic signed [3*W+1:0]   det_s4
);
	localparam int DW = 3*W+2;

	logic signed [2*W:0] lo_s3  [3];
	logic signed [2*W:0] hi_s3  [3];
	logic signed [2*W:0] cof_s3 [9];
	logic signed [DW-1:0] sum;

	for (genvar k = 0; k < 3; k++) begin : g_part
		always_ff @(posedge clk) begin
			if (en) begin
				lo_s3[k] <= row[k] * $signed({1'b0, cof[3*k][W-1:0]});
				hi_s3[k] <= row[k] * $signed(cof[3*k][2*W:W]);
			end
		end
	end

	always_comb begin
		sum = '0;
		for (int k = 0; k < 3; k++) begin
			sum = sum + (DW'(hi_s3[k]) <<< W) + DW'(lo_s3[k]);
		end
	end

	for (genvar i = 0; i < 9; i++) begin : g_pass
		always_ff @(posedge clk) begin
			if (en) begin
				cof_s3[i] <= cof[i];
				cof_s4[i] <= cof_s3[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s4 <= sum;
		end
	end
endmodule

>>> hdl/mi3_div.sv
module mi3_div #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [2*W:0]   cof,
	input  logic signed [3*W+1:0] det,
	output logic        [W-1:0]   val_s,
	output logic                  sat_s
);
	localparam int CW  = 2*W+1;
	localparam int DW  = 3*W+2;
	localparam int NW  = CW+2*F+1;
	localparam int DSW = DW+W;
	localparam int YW  = ((NW > DSW) ? NW : DSW) + 1;

	logic          neg_s0;
	logic [CW-1:0] nmag_s0;
	logic [DW-1:0] dmag_s0;

	logic [YW-1:0] rem_s [W+2];
	logic [DW-1:0] dm_s  [W+2];
	logic [W:0]    q_s   [W+2];
	logic          neg_s [W+2];
	logic          big_s [W+2];

	logic [W+1:0] qinc;
	logic [W:0]   rq;
	logic [W:0]   lim;
	logic         ovf;
	logic [W:0]   mag;
	logic [W:0]   sval;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s0  <= cof[CW-1] ^ det[DW-1];
			nmag_s0 <= cof[CW-1] ? CW'(-cof) : CW'(cof);
			dmag_s0 <= det[DW-1] ? DW'(-det) : DW'(det);
			rem_s[0] <= YW'(nmag_s0) << (2*F+1);
			dm_s[0]  <= dmag_s0;
			q_s[0]   <= '0;
			neg_s[0] <= neg_s0;
			big_s[0] <= (YW'(nmag_s0) << (2*F)) >= (YW'(dmag_s0) << W);
		end
	end

	for (genvar i = 0; i <= W; i++) begin : g_step
		localparam int K = W - i;
		logic [YW:0] diff;
		assign diff = {1'b0, rem_s[i]} - ((YW+1)'(dm_s[i]) << K);
		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[YW]) begin
					rem_s[i+1] <= diff[YW-1:0];
					q_s[i+1]   <= q_s[i] | ((W+1)'(1) << K);
				end else begin
					rem_s[i+1] <= rem_s[i];
					q_s[i+1]   <= q_s[i];
				end
				dm_s[i+1]  <= dm_s[i];
				neg_s[i+1] <= neg_s[i];
				big_s[i+1] <= big_s[i];
			end
		end
	end

	always_comb begin
		qinc = (W+2)'(q_s[W+1]) + (W+2)'(1);
		rq   = qinc[W+1:1];
		lim  = neg_s[W+1] ? ((W+1)'(1) << (W-1)) : (((W+1)'(1) << (W-1)) - (W+1)'(1));
		ovf  = big_s[W+1] || (rq > lim);
		mag  = ovf ? lim : rq;
		sval = neg_s[W+1] ? (W+1)'(-mag) : mag;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s <= sval[W-1:0];
			sat_s <= ovf;
		end
	end
endmodule

>>> hdl/matrix3x3_inverse.sv
// Throughput: one matrix per cycle when not stalled; 2 cofactor stages,
// 2 determinant stages, then a divider per element that resolves one
// quotient bit per stage. A stalled output freezes the whole pipeline.
// Reset clears the valid bits only; datapath registers are not reset.
module matrix3x3_inverse #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [DATA_WIDTH-1:0] m_00,
	input  logic signed [DATA_WIDTH-1:0] m_01,
	input  logic signed [DATA_WIDTH-1:0] m_02,
	input  logic signed [DATA_WIDTH-1:0] m_10,
	input  logic signed [DATA_WIDTH-1:0] m_11,
	input  logic signed [DATA_WIDTH-1:0] m_12,
	input  logic signed [DATA_WIDTH-1:0] m_20,
	input  logic signed [DATA_WIDTH-1:0] m_21,
	input  logic signed [DATA_WIDTH-1:0] m_22,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] inv_00,
	output logic signed [DATA_WIDTH-1:0] inv_01,
	output logic signed [DATA_WIDTH-1:0] inv_02,
	output logic signed [DATA_WIDTH-1:0] inv_10,
	output logic signed [DATA_WIDTH-1:0] inv_11,
	output logic signed [DATA_WIDTH-1:0] inv_12,
	output logic signed [DATA_WIDTH-1:0] inv_20,
	output logic signed [DATA_WIDTH-1:0] inv_21,
	output logic signed [DATA_WIDTH-1:0] inv_22,
	output logic        [1:0]            status
);
	localparam int W    = DATA_WIDTH;
	localparam int DLAT = W + 4;
	localparam int LAT  = DLAT + 4;

	logic en;
	logic [LAT-1:0]  vld_q;
	logic [DLAT-1:0] sing_q;

	logic signed [W-1:0]   m      [9];
	logic signed [2*W:0]   cof_s2 [9];
	logic signed [W-1:0]   row_s2 [3];
	logic signed [2*W:0]   cof_s4 [9];
	logic signed [3*W+1:0] det_s4;
	logic [W-1:0]          val    [9];
	logic [8:0]            sat;
	logic [W-1:0]          res    [9];
	mi3_pkg::status_t      st;

	assign m[0] = m_00;
	assign m[1] = m_01;
	assign m[2] = m_02;
	assign m[3] = m_10;
	assign m[4] = m_11;
	assign m[5] = m_12;
	assign m[6] = m_20;
	assign m[7] = m_21;
	assign m[8] = m_22;

	assign out_valid = vld_q[LAT-1];
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sing_q <= {sing_q[DLAT-2:0], (det_s4 == '0)};
		end
	end

	mi3_cofactor #(.W(W)) u_cof (
		.clk    (clk),
		.en     (en),
		.m      (m),
		.cof_s2 (cof_s2),
		.row_s2 (row_s2)
	);

	mi3_det #(.W(W)) u_det (
		.clk    (clk),
		.en     (en),
		.cof    (cof_s2),
		.row    (row_s2),
		.cof_s4 (cof_s4),
		.det_s4 (det_s4)
	);

	for (genvar i = 0; i < 9; i++) begin : g_div
		mi3_div #(.W(W), .F(FRAC_BITS)) u_div (
			.clk   (clk),
			.en    (en),
			.cof   (cof_s4[i]),
			.det   (det_s4),
			.val_s (val[i]),
			.sat_s (sat[i])
		);
		assign res[i] = sing_q[DLAT-1] ? '0 : val[i];
	end

	always_comb begin
		if (sing_q[DLAT-1]) begin
			st = mi3_pkg::STATUS_SINGULAR;
		end else if (|sat) begin
			st = mi3_pkg::STATUS_SAT;
		end else begin
			st = mi3_pkg::STATUS_OK;
		end
	end

	assign status = st;
	assign inv_00 = res[0];
	assign inv_01 = res[1];
	assign inv_02 = res[2];
	assign inv_10 = res[3];
	assign inv_11 = res[4];
	assign inv_12 = res[5];
	assign inv_20 = res[6];
	assign inv_21 = res[7];
	assign inv_22 = res[8];
endmodule

>>> test/matrix3x3_inverse_tb.sv
module matrix3x3_inverse_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [31:0] elem_t;
	typedef elem_t mat_t [9];
	typedef logic signed [199:0] big_t;

	typedef struct {
		elem_t            inv [9];
		mi3_pkg::status_t st;
	} inverse_t;

	class inverse_scoreboard;
		inverse_t pending_q [$];
		int       errors;
		int       checked;
		int       n_singular;
		int       n_sat;

		function automatic elem_t quotient(big_t cof, big_t det, ref bit sat);
			bit   neg;
			big_t n;
			big_t d;
			big_t q;
			big_t r;
			big_t lim;
			neg = cof[199] ^ det[199];
			n = (cof[199] ? -cof : cof) <<< 32;
			d = det[199] ? -det : det;
			q = $unsigned(n) / $unsigned(d);
			r = $unsigned(n) % $unsigned(d);
			if ($unsigned(r << 1) >= $unsigned(d))
				q = q + 1;
			lim = neg ? (big_t'(1) <<< 31) : ((big_t'(1) <<< 31) - 1);
			if ($unsigned(q) > $unsigned(lim)) begin
				q = lim;
				sat = 1;
			end
			if (neg)
				q = -q;
			return q[31:0];
		endfunction

		function automatic inverse_t invert(mat_t m);
			big_t     a [9];
			big_t     c [9];
			big_t     det;
			bit       sat;
			inverse_t res;
			for (int i = 0; i < 9; i++)
				a[i] = m[i];
			c[0] = a[4] * a[8] - a[5] * a[7];
			c[1] = a[2] * a[7] - a[1] * a[8];
			c[2] = a[1] * a[5] - a[2] * a[4];
			c[3] = a[5] * a[6] - a[3] * a[8];
			c[4] = a[0] * a[8] - a[2] * a[6];
			c[5] = a[2] * a[3] - a[0] * a[5];
			c[6] = a[3] * a[7] - a[4] * a[6];
			c[7] = a[1] * a[6] - a[0] * a[7];
			c[8] = a[0] * a[4] - a[1] * a[3];
			det = a[0] * c[0] + a[1] * c[3] + a[2] * c[6];
			sat = 0;
			if (det == 0) begin
				for (int i = 0; i < 9; i++)
					res.inv[i] = '0;
				res.st = mi3_pkg::STATUS_SINGULAR;
				return res;
			end
			for (int i = 0; i < 9; i++)
				res.inv[i] = quotient(c[i], det, sat);
			res.st = sat ? mi3_pkg::STATUS_SAT : mi3_pkg::STATUS_OK;
			return res;
		endfunction

		function void note_matrix(mat_t m);
			inverse_t e;
			e = invert(m);
			if (e.st == mi3_pkg::STATUS_SINGULAR)
				n_singular++;
			if (e.st == mi3_pkg::STATUS_SAT)
				n_sat++;
			pending_q.push_back(e);
		endfunction

		function void check_inverse(mat_t got, logic [1:0] st);
			inverse_t e;
			if (pending_q.size() == 0) begin
				$error("result with no matrix outstanding");
				errors++;
				return;
			end
			e = pending_q.pop_front();
			checked++;
			for (int i = 0; i < 9; i++)
				if (got[i] !== e.inv[i]) begin
					$error("inv_%0d%0d: expected %0d, actual %0d", i / 3, i % 3,
						e.inv[i], got[i]);
					errors++;
				end
			if (st !== e.st) begin
				$error("status: expected %0d, actual %0d", e.st, st);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic out_valid;
	logic out_ready;
	elem_t m_00, m_01, m_02, m_10, m_11, m_12, m_20, m_21, m_22;
	elem_t inv_00, inv_01, inv_02, inv_10, inv_11, inv_12, inv_20, inv_21, inv_22;
	logic [1:0] status;

	inverse_scoreboard sb;
	bit  quiet;
	int  hold_req;
	int  hold_left;
	int  cycles;

	localparam elem_t ONE = 32'sh0001_0000;
	localparam elem_t MAXV = 32'sh7fff_ffff;
	localparam elem_t MINV = 32'sh8000_0000;
	localparam int LIMIT = 400000;

	matrix3x3_inverse dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.m_00(m_00), .m_01(m_01), .m_02(m_02),
		.m_10(m_10), .m_11(m_11), .m_12(m_12),
		.m_20(m_20), .m_21(m_21), .m_22(m_22),
		.out_valid(out_valid), .out_ready(out_ready),
		.inv_00(inv_00), .inv_01(inv_01), .inv_02(inv_02),
		.inv_10(inv_10), .inv_11(inv_11), .inv_12(inv_12),
		.inv_20(inv_20), .inv_21(inv_21), .inv_22(inv_22),
		.status(status)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: random stalls, long hold on request, none when quiet
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (quiet || $urandom_range(0, 3) != 0) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= 1'b0;
			hold_left = $urandom_range(0, 2);
		end
	end

	always @(posedge clk) begin
		mat_t in_m;
		mat_t out_m;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				in_m = '{m_00, m_01, m_02, m_10, m_11, m_12, m_20, m_21, m_22};
				sb.note_matrix(in_m);
			end
			if (out_valid && out_ready) begin
				out_m = '{inv_00, inv_01, inv_02, inv_10, inv_11, inv_12,
					inv_20, inv_21, inv_22};
				sb.check_inverse(out_m, status);
			end
		end
	end

	task automatic send_matrix(mat_t m);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		{m_00, m_01, m_02, m_10, m_11, m_12, m_20, m_21, m_22} <=
			{m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_diag(elem_t a, elem_t b, elem_t c);
		send_matrix('{a, 0, 0, 0, b, 0, 0, 0, c});
	endtask

	function automatic elem_t rand_elem();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? MAXV : MINV;
			2: return elem_t'($urandom_range(0, 16)) - 8;
			default: return elem_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
		endcase
	endfunction

	task automatic send_random();
		mat_t m;
		for (int i = 0; i < 9; i++)
			m[i] = rand_elem();
		case ($urandom_range(0, 9))
			0: for (int i = 0; i < 3; i++) m[6 + i] = m[i];
			1: for (int i = 0; i < 3; i++) m[3 * i + 2] = m[3 * i + 1] * 2;
			2: for (int i = 0; i < 3; i++) m[3 + i] = 0;
			default: ;
		endcase
		send_matrix(m);
	endtask

	task automatic drain();
		while (sb.pending_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		quiet = 0;
		hold_req = 0;
		hold_left = 0;
		cycles = 0;
		{m_00, m_01, m_02, m_10, m_11, m_12, m_20, m_21, m_22} = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_diag(ONE, ONE, ONE);
		send_diag(-ONE, -ONE, -ONE);
		send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
		send_matrix('{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV});
		send_matrix('{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV});
		send_diag(MAXV, MAXV, MAXV);
		send_diag(MINV, MINV, MINV);
		send_diag(MINV, MAXV, -1);
		send_diag(1, 1, 1);
		send_diag(-1, 2, ONE);
		send_diag(ONE * 2, ONE * 4, -ONE * 8);
		send_matrix('{ONE * 2, 1, 0, 0, ONE, 0, 0, 0, ONE});
		send_matrix('{ONE * 2, 3, 0, 0, ONE, 0, 0, 0, ONE});
		send_matrix('{ONE * 2, -3, 0, 0, ONE, 0, 0, 0, -ONE});
		send_matrix('{ONE * 2, ONE, 0, ONE, 3 * ONE, ONE, 0, ONE, 4 * ONE});
		send_matrix('{1, 2, 3, 4, 5, 6, 7, 8, 10});
		send_matrix('{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
			7 * ONE, 8 * ONE, 9 * ONE});
		send_matrix('{0, ONE, 0, 0, 0, ONE, ONE, 0, 0});
		send_matrix('{MAXV, MINV, 1, -1, MAXV, MINV, MINV, -1, MAXV});

		for (int k = 0; k < 400; k++) begin
			if (k == 120)
				hold_req = 300;
			if (k == 250) begin
				in_valid <= 1'b0;
				drain();
			end
			if (k == 340)
				quiet = 1;
			send_random();
		end
		in_valid <= 1'b0;

		drain();
		repeat (60) @(posedge clk);
		$display("checked %0d inverses: %0d singular, %0d saturated, %0d leftover",
			sb.checked, sb.n_singular, sb.n_sat, sb.pending_q.size());
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

>>> sim.f
hdl/mi3_pkg.sv
hdl/mi3_cofactor.sv
hdl/mi3_det.sv
hdl/mi3_div.sv
hdl/matrix3x3_inverse.sv
test/matrix3x3_inverse_tb.sv
